// ===== rtl/ter_pkg.sv =====
// ----------------------------------------------------------------------------
// ter_pkg
// Shared types, widths and codes of the template event realigner.
// ----------------------------------------------------------------------------
package ter_pkg;

   localparam int TW    = 16;   // signed time arithmetic
   localparam int SMPW  = 16;
   localparam int TSUMW = 22;
   localparam int PRODW = SMPW + TSUMW;
   localparam int ACCW  = 47;
   localparam int TIMEW = 12;
   localparam int SLOTW = 6;

   localparam logic [1:0] OP_LOAD_SAMPLE = 2'd0;
   localparam logic [1:0] OP_LOAD_EVENT  = 2'd1;
   localparam logic [1:0] OP_RUN         = 2'd2;

   localparam logic [2:0] REG_PRE    = 3'd0;
   localparam logic [2:0] REG_POST   = 3'd1;
   localparam logic [2:0] REG_RADIUS = 3'd2;
   localparam logic [2:0] REG_PASSES = 3'd3;
   localparam logic [2:0] REG_CHANS  = 3'd4;
   localparam logic [2:0] REG_RECLEN = 3'd5;
   localparam logic [2:0] REG_EVENTS = 3'd6;

   typedef struct packed {
      logic [4:0]  pre;
      logic [4:0]  post;
      logic [4:0]  radius;
      logic [7:0]  passes;
      logic [2:0]  chans;
      logic [12:0] reclen;
      logic [6:0]  events;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   typedef struct packed {
      logic             push;
      logic [SLOTW-1:0] slot;
      logic [TIMEW-1:0] time_val;
      logic             last;
   } emit_type;

   function automatic logic fits(input logic signed [TW-1:0] x, input logic [4:0] pre,
                                 input logic [4:0] post, input logic [12:0] reclen);
      logic signed [TW-1:0] lo;
      logic signed [TW-1:0] hi;
      logic signed [TW-1:0] rl;
      lo = $signed({{(TW-5){1'b0}}, pre});
      hi = x + $signed({{(TW-5){1'b0}}, post});
      rl = $signed({{(TW-13){1'b0}}, reclen});
      return (x >= lo) && (hi < rl);
   endfunction

endpackage

// ===== rtl/template_event_realigner_core.sv =====
// Load transactions: one per cycle, back to back, no result.
// Run: each pass clears the template store, accumulates every fitting event into the
// template, then correlates each event at each fitting shift on the shared MAC.
// Results: one per event, the next only once the last is taken; not ready during a run.
// Reset: synchronous; control and registers return to defaults, stores undefined until written.
// ----------------------------------------------------------------------------
// template_event_realigner_core
// Iterative template cross-correlation event realigner, top level.
// ----------------------------------------------------------------------------
module template_event_realigner_core #(
   parameter int CHANNELS      = 4,
   parameter int SAMPLES       = 4096,
   parameter int EVENTS        = 64,
   parameter int WINDOW_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // channel_slot, position, sample_value, event_time
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // event_slot, aligned_time
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ter_pkg::*;

   cfg_type          cfg_ff;
   logic             wr_en;
   logic [2:0]       ridx;
   logic             idle;
   logic             go;
   emit_type         emit;
   logic             rv_ff;
   logic [SLOTW-1:0] rslot_ff;
   logic [TIMEW-1:0] rtime_ff;
   logic             rlast_ff;

   assign csr_pready = 1'b1;
   assign ridx       = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pre    <= 5'd10;
         cfg_ff.post   <= 5'd20;
         cfg_ff.radius <= 5'd5;
         cfg_ff.passes <= 8'd10;
         cfg_ff.chans  <= 3'd1;
         cfg_ff.reclen <= 13'd4096;
         cfg_ff.events <= 7'd0;
      end else if (wr_en) begin
         case (ridx)
            REG_PRE:    cfg_ff.pre    <= csr_pwdata[4:0];
            REG_POST:   cfg_ff.post   <= csr_pwdata[4:0];
            REG_RADIUS: cfg_ff.radius <= csr_pwdata[4:0];
            REG_PASSES: cfg_ff.passes <= csr_pwdata[7:0];
            REG_CHANS:  cfg_ff.chans  <= csr_pwdata[2:0];
            REG_RECLEN: cfg_ff.reclen <= csr_pwdata[12:0];
            REG_EVENTS: cfg_ff.events <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         REG_PRE:    csr_prdata = {27'd0, cfg_ff.pre};
         REG_POST:   csr_prdata = {27'd0, cfg_ff.post};
         REG_RADIUS: csr_prdata = {27'd0, cfg_ff.radius};
         REG_PASSES: csr_prdata = {24'd0, cfg_ff.passes};
         REG_CHANS:  csr_prdata = {29'd0, cfg_ff.chans};
         REG_RECLEN: csr_prdata = {19'd0, cfg_ff.reclen};
         REG_EVENTS: csr_prdata = {25'd0, cfg_ff.events};
         default:    csr_prdata = '0;
      endcase
   end

   assign req_tready = idle;
   assign go         = req_tvalid && req_tready;

   ter_seq #(
      .CHANNELS      (CHANNELS),
      .SAMPLES       (SAMPLES),
      .EVENTS        (EVENTS),
      .WINDOW_POINTS (WINDOW_POINTS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .op       (req_tuser),
      .slot     (req_tdata[1:0]),
      .pos      (req_tdata[13:2]),
      .sample   ($signed(req_tdata[29:14])),
      .etime    (req_tdata[41:30]),
      .cfg      (cfg_ff),
      .out_free (!rv_ff),
      .idle     (idle),
      .emit     (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (emit.push) begin
         rv_ff <= 1'b1;
      end else if (rsp_tready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.push) begin
         rslot_ff <= emit.slot;
         rtime_ff <= emit.time_val;
         rlast_ff <= emit.last;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {6'd0, rtime_ff, rslot_ff};
   assign rsp_tlast  = rlast_ff;

endmodule

// ===== rtl/ter_mac.sv =====
// ----------------------------------------------------------------------------
// ter_mac
// Shared multiply-accumulate unit: product register, then 47-bit accumulator.
// ----------------------------------------------------------------------------
module ter_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  ter_pkg::mac_ctl_type              ctl,
   input  logic signed [ter_pkg::SMPW-1:0]   smp,
   input  logic signed [ter_pkg::TSUMW-1:0]  tsum,
   output logic signed [ter_pkg::ACCW-1:0]   acc,
   output logic                              done
);
   import ter_pkg::*;

   logic signed [PRODW-1:0] prod_ff;
   logic                    pv_ff;
   logic                    pf_ff;
   logic                    pl_ff;
   logic signed [ACCW-1:0]  acc_ff;
   logic                    done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pv_ff   <= ctl.valid;
         done_ff <= pv_ff && pl_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= smp * tsum;
      pf_ff   <= ctl.first;
      pl_ff   <= ctl.last;
      if (pv_ff) begin
         acc_ff <= (pf_ff ? '0 : acc_ff) + ACCW'(prod_ff);
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

// ===== rtl/ter_seq.sv =====
// ----------------------------------------------------------------------------
// ter_seq
// Sequencer with sample, template and event stores; drives the shared MAC.
// ----------------------------------------------------------------------------
module ter_seq #(
   parameter int CHANNELS      = 4,
   parameter int SAMPLES       = 4096,
   parameter int EVENTS        = 64,
   parameter int WINDOW_POINTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [1:0]                    op,
   input  logic [1:0]                    slot,
   input  logic [11:0]                   pos,
   input  logic signed [ter_pkg::SMPW-1:0] sample,
   input  logic [ter_pkg::TIMEW-1:0]     etime,
   input  ter_pkg::cfg_type              cfg,
   input  logic                          out_free,
   output logic                          idle,
   output ter_pkg::emit_type             emit
);
   import ter_pkg::*;

   localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNW = $clog2(CHANNELS + 1);
   localparam int AW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int EW  = (EVENTS > 1) ? $clog2(EVENTS) : 1;
   localparam int NW  = $clog2(EVENTS + 1);
   localparam int KW  = $clog2(WINDOW_POINTS);

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_AEV, S_AFIT, S_ARD, S_AWR, S_SEV, S_SFIT,
      S_SOFF, S_DOT, S_WAIT, S_SUPD, S_PEND, S_EMRD, S_EMLD, S_EMWT
   } state_type;

   logic signed [SMPW-1:0]  smem [CHANNELS][SAMPLES];
   logic signed [TSUMW-1:0] tmem [CHANNELS][WINDOW_POINTS];
   logic [TIMEW-1:0]        emem [EVENTS];

   state_type               state_ff;
   logic [CW-1:0]           c_ff;
   logic [KW-1:0]           k_ff;
   logic [EW-1:0]           i_ff;
   logic signed [TW-1:0]    base_ff;
   logic [TIMEW-1:0]        t_ff;
   logic signed [5:0]       s_ff;
   logic                    bv_ff;
   logic signed [5:0]       boff_ff;
   logic signed [ACCW-1:0]  best_ff;
   logic [7:0]              pass_ff;
   logic                    moved_ff;
   logic [NW-1:0]           n_ff;
   logic [CNW-1:0]          chan_ff;
   logic [12:0]             rec_ff;
   logic [4:0]              pre_ff;
   logic [4:0]              post_ff;
   logic [KW-1:0]           klast_ff;
   logic [4:0]              rad_ff;
   logic [7:0]              limit_ff;
   mac_ctl_type             rd_ff;

   logic signed [SMPW-1:0]  s_rd_ff;
   logic signed [TSUMW-1:0] t_rd_ff;
   logic [TIMEW-1:0]        e_rd_ff;

   logic [NW-1:0]           n_in;
   logic [CNW-1:0]          chan_in;
   logic [12:0]             rec_in;
   logic [4:0]              pre_in;
   logic [4:0]              post_in;
   logic [KW-1:0]           klast_in;
   logic signed [TW-1:0]    x_in;
   logic signed [TW-1:0]    xb_in;
   logic [AW-1:0]           sa_in;
   logic                    k_last;
   logic                    c_last;
   logic                    i_last;
   logic                    s_last;
   logic signed [ACCW-1:0]  acc;
   logic                    mac_done;
   logic                    tm_we;
   logic signed [TSUMW-1:0] tm_wd;
   logic                    upd_we;
   logic signed [TW-1:0]    addr_sum;

   always_comb begin
      int pre_i;
      int post_i;
      n_in    = (int'(cfg.events) > EVENTS) ? NW'(EVENTS) : NW'(cfg.events);
      chan_in = (int'(cfg.chans) > CHANNELS) ? CNW'(CHANNELS) : CNW'(cfg.chans);
      rec_in  = (int'(cfg.reclen) > SAMPLES) ? 13'(SAMPLES) : cfg.reclen;
      pre_i   = (int'(cfg.pre) > WINDOW_POINTS - 1) ? WINDOW_POINTS - 1 : int'(cfg.pre);
      post_i  = (pre_i + int'(cfg.post) + 1 > WINDOW_POINTS) ?
                WINDOW_POINTS - 1 - pre_i : int'(cfg.post);
      pre_in   = 5'(pre_i);
      post_in  = 5'(post_i);
      klast_in = KW'(pre_i + post_i);
   end

   assign x_in     = $signed({{(TW-TIMEW){1'b0}}, t_ff}) + TW'(s_ff);
   assign xb_in    = $signed({{(TW-TIMEW){1'b0}}, t_ff}) + TW'(boff_ff);
   assign addr_sum = base_ff + $signed(TW'({1'b0, k_ff}));
   assign sa_in    = addr_sum[AW-1:0];
   assign k_last   = (k_ff == klast_ff);
   assign c_last   = (CNW'(c_ff) + CNW'(1) == chan_ff);
   assign i_last   = (NW'(i_ff) + NW'(1) == n_ff);
   assign s_last   = (s_ff == $signed({1'b0, rad_ff}));
   assign tm_we    = (state_ff == S_CLR) || (state_ff == S_AWR);
   assign tm_wd    = (state_ff == S_CLR) ? '0 : t_rd_ff + TSUMW'(s_rd_ff);
   assign upd_we   = (state_ff == S_SUPD) && bv_ff && (boff_ff != '0);

   // stores
   always_ff @(posedge clock) begin
      if (go && op == OP_LOAD_SAMPLE && int'(slot) < CHANNELS && int'(pos) < SAMPLES) begin
         smem[CW'(slot)][AW'(pos)] <= sample;
      end
      s_rd_ff <= smem[c_ff][sa_in];
   end

   always_ff @(posedge clock) begin
      if (tm_we) begin
         tmem[c_ff][k_ff] <= tm_wd;
      end
      t_rd_ff <= tmem[c_ff][k_ff];
   end

   always_ff @(posedge clock) begin
      if (go && op == OP_LOAD_EVENT && int'(pos) < EVENTS) begin
         emem[EW'(pos)] <= etime;
      end else if (upd_we) begin
         emem[i_ff] <= xb_in[TIMEW-1:0];
      end
      e_rd_ff <= emem[i_ff];
   end

   ter_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (rd_ff),
      .smp   (s_rd_ff),
      .tsum  (t_rd_ff),
      .acc   (acc),
      .done  (mac_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rd_ff    <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
         i_ff     <= '0;
         bv_ff    <= 1'b0;
         moved_ff <= 1'b0;
         pass_ff  <= '0;
      end else begin
         rd_ff <= '0;
         case (state_ff)
            S_IDLE: begin
               if (go && op == OP_RUN) begin
                  n_ff     <= n_in;
                  chan_ff  <= chan_in;
                  rec_ff   <= rec_in;
                  pre_ff   <= pre_in;
                  post_ff  <= post_in;
                  klast_ff <= klast_in;
                  rad_ff   <= cfg.radius;
                  limit_ff <= cfg.passes;
                  i_ff     <= '0;
                  c_ff     <= '0;
                  k_ff     <= '0;
                  pass_ff  <= '0;
                  if (n_in == '0) begin
                     state_ff <= S_IDLE;
                  end else if (chan_in == '0 || cfg.passes == '0) begin
                     state_ff <= S_EMRD;
                  end else begin
                     state_ff <= S_CLR;
                  end
               end
            end
            S_CLR: begin
               if (k_ff == KW'(WINDOW_POINTS - 1)) begin
                  k_ff <= '0;
                  if (c_ff == CW'(CHANNELS - 1)) begin
                     c_ff     <= '0;
                     i_ff     <= '0;
                     moved_ff <= 1'b0;
                     state_ff <= S_AEV;
                  end else begin
                     c_ff <= c_ff + CW'(1);
                  end
               end else begin
                  k_ff <= k_ff + KW'(1);
               end
            end
            S_AEV: state_ff <= S_AFIT;
            S_AFIT: begin
               if (fits($signed({{(TW-TIMEW){1'b0}}, e_rd_ff}), pre_ff, post_ff, rec_ff)) begin
                  base_ff  <= $signed({{(TW-TIMEW){1'b0}}, e_rd_ff}) -
                              $signed({{(TW-5){1'b0}}, pre_ff});
                  c_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= S_ARD;
               end else if (i_last) begin
                  i_ff     <= '0;
                  state_ff <= S_SEV;
               end else begin
                  i_ff     <= i_ff + EW'(1);
                  state_ff <= S_AEV;
               end
            end
            S_ARD: state_ff <= S_AWR;
            S_AWR: begin
               state_ff <= S_ARD;
               if (k_last) begin
                  k_ff <= '0;
                  if (c_last) begin
                     if (i_last) begin
                        i_ff     <= '0;
                        state_ff <= S_SEV;
                     end else begin
                        i_ff     <= i_ff + EW'(1);
                        state_ff <= S_AEV;
                     end
                  end else begin
                     c_ff <= c_ff + CW'(1);
                  end
               end else begin
                  k_ff <= k_ff + KW'(1);
               end
            end
            S_SEV: state_ff <= S_SFIT;
            S_SFIT: begin
               t_ff     <= e_rd_ff;
               s_ff     <= -$signed({1'b0, rad_ff});
               bv_ff    <= 1'b0;
               boff_ff  <= '0;
               state_ff <= S_SOFF;
            end
            S_SOFF: begin
               if (fits(x_in, pre_ff, post_ff, rec_ff)) begin
                  base_ff  <= x_in - $signed({{(TW-5){1'b0}}, pre_ff});
                  c_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= S_DOT;
               end else if (s_last) begin
                  state_ff <= S_SUPD;
               end else begin
                  s_ff <= s_ff + 6'sd1;
               end
            end
            S_DOT: begin
               rd_ff.valid <= 1'b1;
               rd_ff.first <= (c_ff == '0) && (k_ff == '0);
               rd_ff.last  <= k_last && c_last;
               if (k_last) begin
                  k_ff <= '0;
                  if (c_last) begin
                     state_ff <= S_WAIT;
                  end else begin
                     c_ff <= c_ff + CW'(1);
                  end
               end else begin
                  k_ff <= k_ff + KW'(1);
               end
            end
            S_WAIT: begin
               if (mac_done) begin
                  if (!bv_ff || acc > best_ff) begin
                     bv_ff   <= 1'b1;
                     best_ff <= acc;
                     boff_ff <= s_ff;
                  end
                  if (s_last) begin
                     state_ff <= S_SUPD;
                  end else begin
                     s_ff     <= s_ff + 6'sd1;
                     state_ff <= S_SOFF;
                  end
               end
            end
            S_SUPD: begin
               if (upd_we) begin
                  moved_ff <= 1'b1;
               end
               if (i_last) begin
                  state_ff <= S_PEND;
               end else begin
                  i_ff     <= i_ff + EW'(1);
                  state_ff <= S_SEV;
               end
            end
            S_PEND: begin
               pass_ff <= pass_ff + 8'd1;
               c_ff    <= '0;
               k_ff    <= '0;
               i_ff    <= '0;
               if (!moved_ff || pass_ff + 8'd1 == limit_ff) begin
                  state_ff <= S_EMRD;
               end else begin
                  state_ff <= S_CLR;
               end
            end
            S_EMRD: state_ff <= S_EMLD;
            S_EMLD: state_ff <= S_EMWT;
            S_EMWT: begin
               if (out_free) begin
                  if (i_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     i_ff     <= i_ff + EW'(1);
                     state_ff <= S_EMRD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign idle          = (state_ff == S_IDLE);
   assign emit.push     = (state_ff == S_EMLD);
   assign emit.slot     = SLOTW'(i_ff);
   assign emit.time_val = e_rd_ff;
   assign emit.last     = i_last;

endmodule

// ===== rtl/ter_chk.sv =====
// ----------------------------------------------------------------------------
// ter_chk
// Port-level checks of the realigner, bound to the top level.
// ----------------------------------------------------------------------------
module ter_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);
   import ter_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_load_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != OP_RUN |=> req_tready)
      else $error("load transaction dropped ready");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("ready before final result");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind template_event_realigner_core ter_chk u_ter_chk (.*);
